/* design/csdp_pkg.sv */
// Shared package for the clock synthesizer divider planner.
// Holds the sequencer state type, status codes, register map, device register
// addresses and the PLL/multisynth byte packing function. No dependencies.
package csdp_pkg;

  localparam int unsigned NUM_CLOCKS = 3;

  localparam int unsigned DIVD_W = 48;  // dividend width of the shared divider
  localparam int unsigned DIVR_W = 27;  // divisor width of the shared divider
  localparam int unsigned DCNT_W = $clog2(DIVD_W);

  // Status codes of an output word.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_TOO_LOW = 2'd1;
  localparam logic [1:0] STATUS_NO_DIV  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_XTAL     = 3'd0;
  localparam logic [2:0] REG_DEN      = 3'd1;
  localparam logic [2:0] REG_PLL_MIN  = 3'd2;
  localparam logic [2:0] REG_PLL_MAX  = 3'd3;
  localparam logic [2:0] REG_MS_MIN   = 3'd4;
  localparam logic [2:0] REG_MS_MAX   = 3'd5;
  localparam logic [2:0] REG_EVEN_THR = 3'd6;
  localparam logic [2:0] REG_RDIV_MAX = 3'd7;

  // Device register addresses and fixed bytes.
  localparam logic [7:0] ADDR_OUT_CTRL  = 8'd3;
  localparam logic [7:0] ADDR_CLK_CTRL  = 8'd16;
  localparam logic [7:0] ADDR_PLL_A     = 8'd26;
  localparam logic [7:0] ADDR_PLL_B     = 8'd34;
  localparam logic [7:0] ADDR_MS0       = 8'd42;
  localparam logic [7:0] ADDR_PLL_RESET = 8'd177;
  localparam logic [7:0] CLK_PDN        = 8'h80;
  localparam logic [7:0] CLK_ON_PLL_A   = 8'h4C;
  localparam logic [7:0] CLK_ON_PLL_B   = 8'h6C;
  localparam logic [7:0] RST_PLL_A      = 8'h20;
  localparam logic [7:0] RST_PLL_B      = 8'h80;
  localparam logic [7:0] MS_QUARTER_MODE = 8'h0C;
  localparam logic [17:0] P1_OFFSET     = 18'd512;

  // Word positions inside the 21-word write sequence.
  localparam logic [4:0] W_DISABLE  = 5'd0;
  localparam logic [4:0] W_PDN      = 5'd1;
  localparam logic [4:0] W_PLL      = 5'd2;
  localparam logic [4:0] W_MS       = 5'd10;
  localparam logic [4:0] W_PWR_UP   = 5'd18;
  localparam logic [4:0] W_PLL_RST  = 5'd19;
  localparam logic [4:0] W_ENABLE   = 5'd20;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RMUL,
    S_RCHK,
    S_DMUL,
    S_SRCH,
    S_D1GO,
    S_D1WAIT,
    S_NMUL,
    S_D2GO,
    S_D2WAIT,
    S_D3GO,
    S_D3WAIT,
    S_PWORD,
    S_EMIT,
    S_ERR
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // One byte of an eight-byte PLL or multisynth parameter block.
  function automatic logic [7:0] pll_byte(input logic [2:0]  j,
                                          input logic [17:0] p1,
                                          input logic [19:0] p2,
                                          input logic [19:0] p3,
                                          input logic [7:0]  mid);
    logic [7:0] b;
    case (j)
      3'd0:    b = p3[15:8];
      3'd1:    b = p3[7:0];
      3'd2:    b = mid | {6'b0, p1[17:16]};
      3'd3:    b = p1[15:8];
      3'd4:    b = p1[7:0];
      3'd5:    b = {p3[19:16], p2[19:16]};
      3'd6:    b = p2[15:8];
      default: b = p2[7:0];
    endcase
    return b;
  endfunction

endpackage

/* design/clock_synth_divider_planner.sv */
// Top level of the clock synthesizer divider planner.
// Depends on csdp_pkg, csdp_div (shared divider) and csdp_fmt (word formatter).
//
// Usage: a request word on the s_axis channel carries an output number and a
// target frequency. The block picks an R divider exponent, searches the
// multisynth ratio, derives the fractional PLL words and then streams the
// register writes on the m_axis channel, 21 words for a good plan or one
// error word, with tlast on the final word of the request.
// The R exponent check tries the exponents in turn (at most eight), the ratio
// search tries one ratio after another (up to about 2050 at the reset
// configuration), and then two or three divisions, the third skipped when the
// denominator is zero, run on the shared serial divider. Once the first word is
// ready, one word goes out per cycle while the receiver is ready. s_axis_tready is
// high only while the sequencer is idle.
// When the receiver stalls, the output register holds its word and the
// sequence pauses. Reset restores every configuration register to its
// default, sets the output disable mask to all ones and empties the output.
// Configuration registers are written through the APB port at byte address
// 4*index; reads return the current value.
module clock_synth_divider_planner (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [1:0] clock_sel, [29:2] target_hz
  // Register write channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] reg_addr, [15:8] reg_data, [17:16] status
  output logic        m_axis_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [25:0] xtal_q;
  logic [19:0] den_q;
  logic [29:0] pll_min_q, pll_max_q;
  logic [11:0] ms_min_q, ms_max_q;
  logic [27:0] thr_q;
  logic [2:0]  rmax_q;

  csdp_pkg::state_e state_q, state_d;

  logic [1:0]  sel_q;
  logic [27:0] freq_q;
  logic [40:0] lim_q;       // (largest ratio + 1) * requested frequency
  logic [2:0]  rexp_q;
  logic [12:0] div_q;
  logic [47:0] f_q;
  logic [35:0] inc_q;
  logic        step2_q;
  logic [11:0] ratio_q;
  logic [29:0] pll_q;
  logic [29:0] mult_q;
  logic [25:0] rem_q;
  logic [47:0] nd_q;
  logic [19:0] num_q;
  logic [7:0]  fl_q;
  logic [17:0] p1_q;
  logic [19:0] p2_q;
  logic [1:0]  err_q;
  logic [4:0]  widx_q;
  logic [7:0]  mask_q;

  logic        ov_q;
  logic [23:0] od_q;
  logic        ol_q;

  // Shared divider hookup.
  logic                            div_start;
  logic [csdp_pkg::DIVD_W-1:0]     div_dvd;
  logic [csdp_pkg::DIVR_W-1:0]     div_dvs;
  csdp_pkg::div_stat_t             div_stat;
  logic [csdp_pkg::DIVD_W-1:0]     div_quo;
  logic [csdp_pkg::DIVR_W-1:0]     div_rem;

  logic [7:0]  fmt_addr, fmt_data;

  // Decision terms shared by the next-state and datapath logic.
  logic        in_acc, out_free, cfg_wr;
  logic [34:0] target;
  logic        too_fast;   // pll_min / target still exceeds the largest ratio
  logic        f_over, f_in;
  logic        bad_sel;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !ov_q || m_axis_tready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign target   = {7'b0, freq_q} << rexp_q;
  assign too_fast = {18'b0, pll_min_q} >= ({7'b0, lim_q} << rexp_q);
  assign f_over   = (div_q > {1'b0, ms_max_q}) || (f_q > {18'b0, pll_max_q});
  assign f_in     = f_q >= {18'b0, pll_min_q};
  assign bad_sel  = ({30'b0, sel_q} >= 32'(csdp_pkg::NUM_CLOCKS)) || (xtal_q == '0);

  assign s_axis_tready = (state_q == csdp_pkg::S_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      csdp_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (s_axis_tdata[29:2] == '0) ? csdp_pkg::S_ERR : csdp_pkg::S_RMUL;
        end
      end
      csdp_pkg::S_RMUL: state_d = csdp_pkg::S_RCHK;
      csdp_pkg::S_RCHK: begin
        if (too_fast && rexp_q < rmax_q) begin
          state_d = csdp_pkg::S_RCHK;
        end else if (too_fast || bad_sel) begin
          state_d = csdp_pkg::S_ERR;
        end else begin
          state_d = csdp_pkg::S_DMUL;
        end
      end
      csdp_pkg::S_DMUL: state_d = csdp_pkg::S_SRCH;
      csdp_pkg::S_SRCH: begin
        if (f_over) begin
          state_d = csdp_pkg::S_ERR;
        end else if (f_in) begin
          state_d = csdp_pkg::S_D1GO;
        end
      end
      csdp_pkg::S_D1GO: state_d = csdp_pkg::S_D1WAIT;
      csdp_pkg::S_D1WAIT: if (div_stat.done) state_d = csdp_pkg::S_NMUL;
      csdp_pkg::S_NMUL: state_d = csdp_pkg::S_D2GO;
      csdp_pkg::S_D2GO: state_d = csdp_pkg::S_D2WAIT;
      csdp_pkg::S_D2WAIT: begin
        if (div_stat.done) begin
          state_d = (den_q == '0) ? csdp_pkg::S_PWORD : csdp_pkg::S_D3GO;
        end
      end
      csdp_pkg::S_D3GO: state_d = csdp_pkg::S_D3WAIT;
      csdp_pkg::S_D3WAIT: if (div_stat.done) state_d = csdp_pkg::S_PWORD;
      csdp_pkg::S_PWORD: state_d = csdp_pkg::S_EMIT;
      csdp_pkg::S_EMIT: begin
        if (out_free && widx_q == csdp_pkg::W_ENABLE) state_d = csdp_pkg::S_IDLE;
      end
      csdp_pkg::S_ERR: if (out_free) state_d = csdp_pkg::S_IDLE;
      default: state_d = csdp_pkg::S_IDLE;
    endcase
  end

  // Divider operand selection.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = {18'b0, pll_q};
    div_dvs   = {1'b0, xtal_q};
    case (state_q)
      csdp_pkg::S_D1GO: begin
        div_start = 1'b1;
      end
      csdp_pkg::S_D2GO: begin
        div_start = 1'b1;
        div_dvd   = nd_q;
        div_dvs   = {xtal_q, 1'b0};
      end
      csdp_pkg::S_D3GO: begin
        div_start = 1'b1;
        div_dvd   = {21'b0, num_q, 7'b0};
        div_dvs   = {7'b0, den_q};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  csdp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .stat_o     (div_stat),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  csdp_fmt u_fmt (
    .widx_i  (widx_q),
    .sel_i   (sel_q),
    .rexp_i  (rexp_q),
    .ratio_i (ratio_q),
    .p1_i    (p1_q),
    .p2_i    (p2_q),
    .den_i   (den_q),
    .mask_i  (mask_q),
    .addr_o  (fmt_addr),
    .data_o  (fmt_data)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= csdp_pkg::S_IDLE;
      ov_q      <= 1'b0;
      widx_q    <= '0;
      mask_q    <= 8'hFF;
      xtal_q    <= 26'd25000000;
      den_q     <= 20'd1048575;
      pll_min_q <= 30'd600000000;
      pll_max_q <= 30'd900000000;
      ms_min_q  <= 12'd4;
      ms_max_q  <= 12'd2048;
      thr_q     <= 28'd1000000;
      rmax_q    <= 3'd7;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        case (paddr[4:2])
          csdp_pkg::REG_XTAL:     xtal_q    <= pwdata[25:0];
          csdp_pkg::REG_DEN:      den_q     <= pwdata[19:0];
          csdp_pkg::REG_PLL_MIN:  pll_min_q <= pwdata[29:0];
          csdp_pkg::REG_PLL_MAX:  pll_max_q <= pwdata[29:0];
          csdp_pkg::REG_MS_MIN:   ms_min_q  <= pwdata[11:0];
          csdp_pkg::REG_MS_MAX:   ms_max_q  <= pwdata[11:0];
          csdp_pkg::REG_EVEN_THR: thr_q     <= pwdata[27:0];
          default:                rmax_q    <= pwdata[2:0];
        endcase
      end
      // A new word loads the output register; otherwise a taken word empties it.
      if ((state_q == csdp_pkg::S_EMIT || state_q == csdp_pkg::S_ERR) && out_free) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
      if (state_q == csdp_pkg::S_PWORD) widx_q <= '0;
      if (state_q == csdp_pkg::S_EMIT && out_free) begin
        widx_q <= widx_q + 1'b1;
        if (widx_q == csdp_pkg::W_ENABLE) mask_q <= fmt_data;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      csdp_pkg::S_IDLE: begin
        sel_q  <= s_axis_tdata[1:0];
        freq_q <= s_axis_tdata[29:2];
        err_q  <= csdp_pkg::STATUS_TOO_LOW;
      end
      csdp_pkg::S_RMUL: begin
        lim_q  <= ({1'b0, ms_max_q} + 13'd1) * freq_q;
        rexp_q <= '0;
      end
      csdp_pkg::S_RCHK: begin
        if (too_fast && rexp_q < rmax_q) begin
          rexp_q <= rexp_q + 1'b1;
        end else if (too_fast) begin
          err_q <= csdp_pkg::STATUS_TOO_LOW;
        end else begin
          err_q <= csdp_pkg::STATUS_NO_DIV;
        end
      end
      csdp_pkg::S_DMUL: begin
        div_q   <= (ms_min_q < 12'd4) ? 13'd4 : {1'b0, ms_min_q};
        f_q     <= 48'(((ms_min_q < 12'd4) ? 13'd4 : {1'b0, ms_min_q}) * target);
        step2_q <= target >= {7'b0, thr_q};
        inc_q   <= (target >= {7'b0, thr_q}) ? {target, 1'b0} : {1'b0, target};
      end
      csdp_pkg::S_SRCH: begin
        ratio_q <= div_q[11:0];
        pll_q   <= f_q[29:0];
        div_q   <= div_q + (step2_q ? 13'd2 : 13'd1);
        f_q     <= f_q + {12'b0, inc_q};
      end
      csdp_pkg::S_D1WAIT: begin
        mult_q <= div_quo[29:0];
        rem_q  <= div_rem[25:0];
      end
      csdp_pkg::S_NMUL: begin
        nd_q <= {46'(rem_q * den_q), 1'b0} + {22'b0, xtal_q};
      end
      csdp_pkg::S_D2WAIT: begin
        num_q <= div_quo[19:0];
        fl_q  <= '0;
      end
      csdp_pkg::S_D3WAIT: begin
        fl_q <= div_quo[7:0];
      end
      csdp_pkg::S_PWORD: begin
        p1_q <= {mult_q[10:0], 7'b0} + {10'b0, fl_q} - csdp_pkg::P1_OFFSET;
        p2_q <= {num_q[12:0], 7'b0} - 20'(den_q * fl_q);
      end
      default: begin
        err_q <= err_q;
      end
    endcase
    if (state_q == csdp_pkg::S_EMIT && out_free) begin
      od_q <= {6'b0, csdp_pkg::STATUS_OK, fmt_data, fmt_addr};
      ol_q <= (widx_q == csdp_pkg::W_ENABLE);
    end
    if (state_q == csdp_pkg::S_ERR && out_free) begin
      od_q <= {6'b0, err_q, 8'd0, 8'd0};
      ol_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;

  // Configuration read-back.
  always_comb begin
    case (paddr[4:2])
      csdp_pkg::REG_XTAL:     prdata = {6'b0, xtal_q};
      csdp_pkg::REG_DEN:      prdata = {12'b0, den_q};
      csdp_pkg::REG_PLL_MIN:  prdata = {2'b0, pll_min_q};
      csdp_pkg::REG_PLL_MAX:  prdata = {2'b0, pll_max_q};
      csdp_pkg::REG_MS_MIN:   prdata = {20'b0, ms_min_q};
      csdp_pkg::REG_MS_MAX:   prdata = {20'b0, ms_max_q};
      csdp_pkg::REG_EVEN_THR: prdata = {4'b0, thr_q};
      default:                prdata = {29'b0, rmax_q};
    endcase
  end
  assign pready = 1'b1;

  // An accepted request keeps the sequencer busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("request accepted while planner still idle");

  // Error words are always the final word of a request.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[17:16] != csdp_pkg::STATUS_OK) |-> m_axis_tlast)
    else $error("error word without last");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == csdp_pkg::S_D1WAIT || state_q == csdp_pkg::S_D2WAIT ||
                       state_q == csdp_pkg::S_D3WAIT))
    else $error("divider result arrived outside a wait state");

  // A division is only started once the previous one has finished.
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // The word counter never passes the end of the sequence while emitting.
  a_widx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csdp_pkg::S_EMIT) |-> (widx_q <= csdp_pkg::W_ENABLE))
    else $error("word index past end of sequence");

endmodule

/* design/csdp_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on csdp_pkg for widths and the status struct.
module csdp_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [csdp_pkg::DIVD_W-1:0]     dividend_i,
  input  logic [csdp_pkg::DIVR_W-1:0]     divisor_i,
  output csdp_pkg::div_stat_t             stat_o,
  output logic [csdp_pkg::DIVD_W-1:0]     quo_o,
  output logic [csdp_pkg::DIVR_W-1:0]     rem_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [csdp_pkg::DCNT_W-1:0]     cnt_q, cnt_d;
  logic [csdp_pkg::DIVD_W-1:0]     quo_q, quo_d;
  logic [csdp_pkg::DIVR_W-1:0]     rem_q, rem_d;
  logic [csdp_pkg::DIVR_W-1:0]     dvs_q, dvs_d;
  logic [csdp_pkg::DIVR_W+1:0]     diff;

  // Trial subtract of the divisor from the partial remainder with the next bit.
  assign diff = {1'b0, rem_q, quo_q[csdp_pkg::DIVD_W-1]} - {2'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[csdp_pkg::DIVD_W-2:0], ~diff[csdp_pkg::DIVR_W+1]};
      if (!diff[csdp_pkg::DIVR_W+1]) begin
        rem_d = diff[csdp_pkg::DIVR_W-1:0];
      end else begin
        rem_d = {rem_q[csdp_pkg::DIVR_W-2:0], quo_q[csdp_pkg::DIVD_W-1]};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == csdp_pkg::DCNT_W'(csdp_pkg::DIVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;
  assign rem_o       = rem_q;

endmodule

/* design/csdp_fmt.sv */
// Address and data of one word of the 21-word register write sequence.
// Depends on csdp_pkg for addresses, word positions and byte packing.
module csdp_fmt (
  input  logic [4:0]  widx_i,
  input  logic [1:0]  sel_i,
  input  logic [2:0]  rexp_i,
  input  logic [11:0] ratio_i,
  input  logic [17:0] p1_i,
  input  logic [19:0] p2_i,
  input  logic [19:0] den_i,
  input  logic [7:0]  mask_i,
  output logic [7:0]  addr_o,
  output logic [7:0]  data_o
);

  logic       pll_a;
  logic [7:0] bit_sel;
  logic [7:0] mid;
  logic [17:0] ms_p1;
  logic [7:0] pll_base;
  logic [7:0] ms_base;
  logic [4:0] jp, jm;

  assign pll_a    = (sel_i == 2'd0);
  assign bit_sel  = 8'd1 << sel_i;
  assign mid      = {1'b0, rexp_i, 4'b0} |
                    ((ratio_i == 12'd4) ? csdp_pkg::MS_QUARTER_MODE : 8'd0);
  assign ms_p1    = {ratio_i[10:0], 7'b0} - csdp_pkg::P1_OFFSET;
  assign pll_base = pll_a ? csdp_pkg::ADDR_PLL_A : csdp_pkg::ADDR_PLL_B;
  assign ms_base  = csdp_pkg::ADDR_MS0 + {3'b0, sel_i, 3'b0};
  assign jp       = widx_i - csdp_pkg::W_PLL;
  assign jm       = widx_i - csdp_pkg::W_MS;

  always_comb begin
    addr_o = csdp_pkg::ADDR_OUT_CTRL;
    data_o = mask_i | bit_sel;
    if (widx_i == csdp_pkg::W_DISABLE) begin
      addr_o = csdp_pkg::ADDR_OUT_CTRL;
      data_o = mask_i | bit_sel;
    end else if (widx_i == csdp_pkg::W_PDN) begin
      addr_o = csdp_pkg::ADDR_CLK_CTRL + {6'b0, sel_i};
      data_o = csdp_pkg::CLK_PDN;
    end else if (widx_i < csdp_pkg::W_MS) begin
      addr_o = pll_base + {5'b0, jp[2:0]};
      data_o = csdp_pkg::pll_byte(jp[2:0], p1_i, p2_i, den_i, 8'd0);
    end else if (widx_i < csdp_pkg::W_PWR_UP) begin
      addr_o = ms_base + {5'b0, jm[2:0]};
      data_o = csdp_pkg::pll_byte(jm[2:0], ms_p1, 20'd0, 20'd1, mid);
    end else if (widx_i == csdp_pkg::W_PWR_UP) begin
      addr_o = csdp_pkg::ADDR_CLK_CTRL + {6'b0, sel_i};
      data_o = pll_a ? csdp_pkg::CLK_ON_PLL_A : csdp_pkg::CLK_ON_PLL_B;
    end else if (widx_i == csdp_pkg::W_PLL_RST) begin
      addr_o = csdp_pkg::ADDR_PLL_RESET;
      data_o = pll_a ? csdp_pkg::RST_PLL_A : csdp_pkg::RST_PLL_B;
    end else begin
      addr_o = csdp_pkg::ADDR_OUT_CTRL;
      data_o = mask_i & ~bit_sel;
    end
  end

endmodule

/* bench/clock_synth_divider_planner_tb.sv */
// Self-checking bench for clock_synth_divider_planner: frequency requests in,
// device register write words out, checked against a behavioral planner.
// Depends on csdp_pkg and the planner RTL.
`timescale 1ns / 1ps

typedef struct {
  logic [7:0] addr;
  logic [7:0] data;
  logic [1:0] status;
  logic       last;
} reg_write_t;

class plan_scoreboard;
  // Configuration and state copies of the block.
  logic [63:0] xtal, den, pll_lo, pll_hi, ms_lo, ms_hi, even_thr, rexp_max;
  logic [7:0]  dis_mask;
  reg_write_t  write_q[$];
  int          n_err;

  function void reset_cfg();
    xtal = 25000000; den = 1048575; pll_lo = 600000000; pll_hi = 900000000;
    ms_lo = 4; ms_hi = 2048; even_thr = 1000000; rexp_max = 7;
    dis_mask = 8'hFF;
    n_err = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      csdp_pkg::REG_XTAL:     xtal     = 64'(v[25:0]);
      csdp_pkg::REG_DEN:      den      = 64'(v[19:0]);
      csdp_pkg::REG_PLL_MIN:  pll_lo   = 64'(v[29:0]);
      csdp_pkg::REG_PLL_MAX:  pll_hi   = 64'(v[29:0]);
      csdp_pkg::REG_MS_MIN:   ms_lo    = 64'(v[11:0]);
      csdp_pkg::REG_MS_MAX:   ms_hi    = 64'(v[11:0]);
      csdp_pkg::REG_EVEN_THR: even_thr = 64'(v[27:0]);
      default:                rexp_max = 64'(v[2:0]);
    endcase
  endfunction

  function void push(logic [7:0] a, logic [7:0] d, logic [1:0] s, logic l);
    reg_write_t w;
    w.addr = a; w.data = d; w.status = s; w.last = l;
    write_q.push_back(w);
  endfunction

  // Eight parameter bytes of a PLL or multisynth block.
  function void push_block(logic [7:0] base, logic [17:0] p1, logic [19:0] p2,
                           logic [19:0] p3, logic [7:0] mid);
    push(base,          p3[15:8], csdp_pkg::STATUS_OK, 1'b0);
    push(8'(base + 1), p3[7:0], csdp_pkg::STATUS_OK, 1'b0);
    push(8'(base + 2), mid | {6'b0, p1[17:16]}, csdp_pkg::STATUS_OK, 1'b0);
    push(8'(base + 3), p1[15:8], csdp_pkg::STATUS_OK, 1'b0);
    push(8'(base + 4), p1[7:0], csdp_pkg::STATUS_OK, 1'b0);
    push(8'(base + 5), {p3[19:16], p2[19:16]}, csdp_pkg::STATUS_OK, 1'b0);
    push(8'(base + 6), p2[15:8], csdp_pkg::STATUS_OK, 1'b0);
    push(8'(base + 7), p2[7:0], csdp_pkg::STATUS_OK, 1'b0);
  endfunction

  // Plans one accepted request and queues the register writes it causes.
  function void note_request(logic [1:0] sel, logic [27:0] hz);
    logic [63:0] rexp, tgt, step, ratio, pll, mult, rem, num, fl, f;
    logic [17:0] p1, ms_p1;
    logic [19:0] p2;
    logic [7:0]  mid, bitm;
    logic        found, pll_a;
    if (hz == 0) begin
      push(8'd0, 8'd0, csdp_pkg::STATUS_TOO_LOW, 1'b1);
      return;
    end
    rexp = 0;
    tgt = 64'(hz);
    while (pll_lo / tgt > ms_hi && rexp < rexp_max) begin
      rexp++;
      tgt = 64'(hz) << rexp;
    end
    if (pll_lo / tgt > ms_hi) begin
      push(8'd0, 8'd0, csdp_pkg::STATUS_TOO_LOW, 1'b1);
      return;
    end
    if (sel >= csdp_pkg::NUM_CLOCKS || xtal == 0) begin
      push(8'd0, 8'd0, csdp_pkg::STATUS_NO_DIV, 1'b1);
      return;
    end
    step = (tgt >= even_thr) ? 2 : 1;
    found = 1'b0;
    ratio = 0;
    pll = 0;
    for (logic [63:0] d = (ms_lo < 4) ? 4 : ms_lo; d <= ms_hi && !found; d += step) begin
      f = d * tgt;
      if (f >= pll_lo && f <= pll_hi) begin
        ratio = d; pll = f; found = 1'b1;
      end
    end
    if (!found) begin
      push(8'd0, 8'd0, csdp_pkg::STATUS_NO_DIV, 1'b1);
      return;
    end
    mult = pll / xtal;
    rem  = pll % xtal;
    num  = (2 * rem * den + xtal) / (2 * xtal);
    fl   = (den != 0) ? (128 * num) / den : 0;
    p1   = 18'(128 * mult + fl - 64'(csdp_pkg::P1_OFFSET));
    p2   = 20'(128 * num - den * fl);
    ms_p1 = 18'(128 * ratio - 64'(csdp_pkg::P1_OFFSET));
    mid  = {1'b0, rexp[2:0], 4'b0} | ((ratio == 4) ? csdp_pkg::MS_QUARTER_MODE : 8'h00);
    pll_a = (sel == 0);
    bitm = 8'd1 << sel;
    dis_mask = dis_mask | bitm;
    push(csdp_pkg::ADDR_OUT_CTRL, dis_mask, csdp_pkg::STATUS_OK, 1'b0);
    push(csdp_pkg::ADDR_CLK_CTRL + sel, csdp_pkg::CLK_PDN, csdp_pkg::STATUS_OK, 1'b0);
    push_block(pll_a ? csdp_pkg::ADDR_PLL_A : csdp_pkg::ADDR_PLL_B, p1, p2, den[19:0],
               8'h00);
    push_block(8'(csdp_pkg::ADDR_MS0 + 8 * sel), ms_p1, 20'd0, 20'd1, mid);
    push(csdp_pkg::ADDR_CLK_CTRL + sel,
         pll_a ? csdp_pkg::CLK_ON_PLL_A : csdp_pkg::CLK_ON_PLL_B, csdp_pkg::STATUS_OK, 1'b0);
    push(csdp_pkg::ADDR_PLL_RESET, pll_a ? csdp_pkg::RST_PLL_A : csdp_pkg::RST_PLL_B,
         csdp_pkg::STATUS_OK, 1'b0);
    dis_mask = dis_mask & ~bitm;
    push(csdp_pkg::ADDR_OUT_CTRL, dis_mask, csdp_pkg::STATUS_OK, 1'b1);
  endfunction

  function void check_write(logic [7:0] a, logic [7:0] d, logic [1:0] s, logic l);
    reg_write_t w;
    if (write_q.size() == 0) begin
      n_err++;
      if (n_err <= 10)
        $display("unexpected word: addr %0d data %h status %0d last %0d", a, d, s, l);
      return;
    end
    w = write_q.pop_front();
    if (w.addr !== a || w.data !== d || w.status !== s || w.last !== l) begin
      n_err++;
      if (n_err <= 10)
        $display("word differs: exp addr %0d data %h st %0d last %0d; got %0d %h %0d %0d",
                 w.addr, w.data, w.status, w.last, a, d, s, l);
    end
  endfunction
endclass

module clock_synth_divider_planner_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [1:0] clock_sel, [29:2] target_hz
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [7:0] reg_addr, [15:8] reg_data, [17:16] status
  logic        m_axis_tlast;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  plan_scoreboard sb;
  int send_idle_pct = 10;   // percent of words after which the sender idles
  int recv_idle_pct = 79;   // percent of cycles in which the receiver idles
  bit hold_req = 1'b0;      // asks the receiver for one long hold-off
  int quiet_cycles = 0;

  clock_synth_divider_planner uut (.*);

  always #5 clk_i = ~clk_i;

  // Receiver: checks every accepted word, then decides its next ready.
  // A requested hold-off is counted here so the sender keeps running.
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      sb.check_write(m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[17:16],
                     m_axis_tlast);
    if (hold_req && hold_left == 0) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= 40000) begin
      $display("clock_synth_divider_planner: mismatch");
      $finish;
    end
  end

  // APB write: setup phase, access phase, then the bus idles before the model copy is updated.
  task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic cfg_all(logic [31:0] xt, logic [31:0] dn, logic [31:0] lo, logic [31:0] hi,
                         logic [31:0] mlo, logic [31:0] mhi, logic [31:0] thr,
                         logic [31:0] rx);
    cfg_write(csdp_pkg::REG_XTAL, xt);      cfg_write(csdp_pkg::REG_DEN, dn);
    cfg_write(csdp_pkg::REG_PLL_MIN, lo);   cfg_write(csdp_pkg::REG_PLL_MAX, hi);
    cfg_write(csdp_pkg::REG_MS_MIN, mlo);   cfg_write(csdp_pkg::REG_MS_MAX, mhi);
    cfg_write(csdp_pkg::REG_EVEN_THR, thr); cfg_write(csdp_pkg::REG_RDIV_MAX, rx);
  endtask

  // Offers one request word and returns at the edge where it is taken, or after the idle gap that may follow.
  // The valid is only lowered when a gap follows, never between two words.
  task automatic send_request(logic [1:0] sel, logic [27:0] hz);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, hz, sel};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(sel, hz);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Sender pause: the valid drops and every expected word has to drain.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.write_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Random request: mostly plausible output frequencies spread over many
  // octaves, some fully random words, and now and then an unused output.
  task automatic random_requests(int n);
    logic [1:0]  sel;
    logic [27:0] hz;
    int          k;
    repeat (n) begin
      sel = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
      if ($urandom_range(3) == 0) begin
        hz = 28'($urandom);
      end else begin
        k = $urandom_range(10, 28);
        hz = 28'($urandom) & 28'((64'd1 << k) - 1);
        hz[k-1] = 1'b1;
      end
      send_request(sel, hz);
    end
  endtask

  initial begin
    sb = new();
    sb.reset_cfg();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset configuration: zero target, too low,
    // the widest word, a ratio of four, even stepping, an unused output.
    send_request(2'd0, 28'd0);
    send_request(2'd1, 28'd1);
    send_request(2'd2, 28'd2000);
    send_request(2'd0, 28'd2289);
    send_request(2'd1, 28'd8000);
    send_request(2'd2, 28'd999999);
    send_request(2'd0, 28'd1000000);
    send_request(2'd1, 28'd10000000);
    send_request(2'd2, 28'd100000000);
    send_request(2'd0, 28'd150000000);
    send_request(2'd1, 28'd200000000);
    send_request(2'd0, 28'hFFFFFFF);
    send_request(2'd3, 28'd10000000);
    send_request(2'd3, 28'hFFFFFFF);
    send_request(2'd2, 28'h5555555);
    send_request(2'd1, 28'hAAAAAAA);
    drain();

    // Zero crystal and zero denominator, both outside the usual ranges.
    cfg_write(csdp_pkg::REG_XTAL, 32'd0);
    send_request(2'd0, 28'd10000000);
    send_request(2'd1, 28'd0);
    drain();
    cfg_write(csdp_pkg::REG_XTAL, 32'd27000000);
    cfg_write(csdp_pkg::REG_DEN, 32'd0);
    send_request(2'd0, 28'd12345678);
    send_request(2'd2, 28'd33000000);
    drain();

    // Random requests at the reset values, sender and receiver idling.
    cfg_all(25000000, 1048575, 600000000, 900000000, 4, 2048, 1000000, 7);
    hold_req = 1'b1;
    random_requests(30);
    drain();

    // Extreme window: only ratio four, no R divider, widest PLL range.
    send_idle_pct = 79; recv_idle_pct = 10;
    cfg_all(40000000, 1, 1, 1000000000, 4, 4, 268435455, 0);
    random_requests(30);
    drain();

    // Only the largest ratio, narrow window, even stepping everywhere.
    cfg_all(10000000, 1048575, 400000000, 800000000, 2048, 2048, 0, 7);
    random_requests(25);
    drain();

    // No random idling apart from one long receiver hold-off; ratios from below four, odd crystal and mid denominator.
    send_idle_pct = 0; recv_idle_pct = 0;
    cfg_all(33333333, 524288, 500000000, 1000000000, 1, 900, 5000000, 3);
    hold_req = 1'b1;
    random_requests(30);
    drain();

    repeat (100) @(posedge clk_i);
    if (sb.n_err == 0 && sb.write_q.size() == 0)
      $display("clock_synth_divider_planner: match");
    else
      $display("clock_synth_divider_planner: mismatch");
    $finish;
  end

endmodule
